FILE: hw/rtl/npd_pkg.sv
// Package for the nested priority dispatcher.
// Holds sizes, request and status codes, and the pending queue types.
// No dependencies.
`timescale 1ns / 1ps

package npd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NEST_DEPTH  = 16;
  localparam int TAG_BITS    = 16;

  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int NA_W   = $clog2(NEST_DEPTH);
  localparam int NC_W   = $clog2(NEST_DEPTH + 1);
  localparam int PRIO_W = 9;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 3;

  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [TAG_BITS-1:0]      tag_t;

  localparam logic [TYPE_W-1:0] REQ_CALL     = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_DONE     = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_POSTPONE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RESUME   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_RAISE    = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_RESTORE  = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_CHECK    = 3'd6;

  localparam logic [STAT_W-1:0] ST_STARTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BACK    = 3'd2;
  localparam logic [STAT_W-1:0] ST_OK      = 3'd3;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd4;
  localparam logic [STAT_W-1:0] ST_REFUSED = 3'd5;
  localparam logic [STAT_W-1:0] ST_NESTERR = 3'd6;

  typedef struct packed {
    prio_t prio;
    tag_t  tag;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   take;
    entry_t ent;
  } q_cmd_t;

  typedef struct packed {
    logic            busy;
    logic [QC_W-1:0] count;
    entry_t          head;
  } q_stat_t;

endpackage

FILE: hw/rtl/npd_if.sv
// Handshake interfaces for the dispatcher's request and result channels.
// Depends on npd_pkg.
`timescale 1ns / 1ps

interface npd_in_if import npd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  prio_t             priority_req;
  tag_t              job_tag;

  modport source (output valid, req_type, priority_req, job_tag, input ready);
  modport sink (input valid, req_type, priority_req, job_tag, output ready);
endinterface

interface npd_out_if import npd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  tag_t              start_tag;
  prio_t             start_priority;
  prio_t             previous_level;
  prio_t             current_level;
  logic [QC_W-1:0]   pending_count;
  logic              postponed;

  modport source (output valid, status, start_tag, start_priority, previous_level,
                  current_level, pending_count, postponed, input ready);
  modport sink (input valid, status, start_tag, start_priority, previous_level,
                current_level, pending_count, postponed, output ready);
endinterface

FILE: hw/rtl/npd_queue.sv
// Sorted pending store: a single-port memory with a step sequencer that shifts
// one entry per step on insert and on removal of the head. Depends on npd_pkg.
`timescale 1ns / 1ps

module npd_queue import npd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_cmd_t  cmd,
  output q_stat_t stat
);

  localparam logic [2:0] Q_IDLE    = 3'd0;
  localparam logic [2:0] Q_INS_RD  = 3'd1;
  localparam logic [2:0] Q_INS_CMP = 3'd2;
  localparam logic [2:0] Q_TK_RD   = 3'd3;
  localparam logic [2:0] Q_TK_WR   = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [QC_W-1:0] used_r, used_nxt;
  logic [QA_W-1:0] idx_r, idx_nxt;
  entry_t          new_r, new_nxt;
  entry_t          head_r;
  entry_t          rdata_r;
  entry_t          mem [QUEUE_DEPTH];

  logic            we;
  logic [QA_W-1:0] waddr;
  entry_t          wdata;
  logic            re;
  logic [QA_W-1:0] raddr;

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    new_nxt   = new_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = new_r;
    re        = 1'b0;
    raddr     = idx_r;
    case (state_r)
      Q_IDLE: begin
        if (cmd.ins) begin
          new_nxt   = cmd.ent;
          idx_nxt   = used_r[QA_W-1:0];
          state_nxt = Q_INS_RD;
        end else if (cmd.take) begin
          if (used_r == QC_W'(1)) begin
            used_nxt = used_r - 1'b1;
          end else begin
            idx_nxt   = '0;
            state_nxt = Q_TK_RD;
          end
        end
      end
      Q_INS_RD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          used_nxt  = used_r + 1'b1;
          state_nxt = Q_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = idx_r - 1'b1;
          state_nxt = Q_INS_CMP;
        end
      end
      Q_INS_CMP: begin
        we = 1'b1;
        if ($signed(rdata_r.prio) >= $signed(new_r.prio)) begin
          used_nxt  = used_r + 1'b1;
          state_nxt = Q_IDLE;
        end else begin
          wdata     = rdata_r;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = Q_INS_RD;
        end
      end
      Q_TK_RD: begin
        re        = 1'b1;
        raddr     = idx_r + 1'b1;
        state_nxt = Q_TK_WR;
      end
      Q_TK_WR: begin
        we    = 1'b1;
        wdata = rdata_r;
        if (QC_W'(idx_r) + QC_W'(2) == used_r) begin
          used_nxt  = used_r - 1'b1;
          state_nxt = Q_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = Q_TK_RD;
        end
      end
      default: begin
        state_nxt = Q_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    new_r <= new_nxt;
    if (we && waddr == '0) begin
      head_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign stat.busy  = (state_r != Q_IDLE);
  assign stat.count = used_r;
  assign stat.head  = head_r;

endmodule

FILE: hw/rtl/nested_priority_dispatcher_unit.sv
// Nested priority dispatcher top level: request sequencer, nesting stack and
// result register. Depends on npd_pkg, npd_if and npd_queue.
`timescale 1ns / 1ps

// The block handles one request at a time and answers each with one result.
// A request that does not touch the pending queue goes from evaluation straight
// to the result register. A queued call shifts each lower-priority entry it
// moves past up by one place, and a start taken from the queue shifts every
// other entry still waiting down by one place; the request waits in S_WAITQ
// until the queue is idle again. The longest request is a call that moves past
// QUEUE_DEPTH - 1 entries to the head, since the single-port pending memory is
// shifted one entry per step.
// The block takes no new request until the previous result has been loaded
// into the output register.

module nested_priority_dispatcher_unit import npd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  npd_in_if.sink      in_req,
  npd_out_if.source   out_rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_WAITQ = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  prio_t             level_r, level_nxt;
  logic              postp_r, postp_nxt;
  logic [NC_W-1:0]   depth_r, depth_nxt;

  logic [TYPE_W-1:0] typ_r;
  prio_t             prio_r;
  tag_t              tag_r;

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  tag_t              res_tag_r, res_tag_nxt;
  prio_t             res_sprio_r, res_sprio_nxt;
  prio_t             res_prev_r, res_prev_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  tag_t              out_tag_r;
  prio_t             out_sprio_r;
  prio_t             out_prev_r;
  prio_t             out_level_r;
  logic [QC_W-1:0]   out_count_r;
  logic              out_postp_r;
  logic              out_load;

  prio_t             stack [NEST_DEPTH];
  prio_t             stk_rdata_r;
  logic [NC_W-1:0]   depth_m1;
  logic              stk_we;

  q_cmd_t            q_cmd;
  q_stat_t           q_stat;

  logic              in_fire;
  logic              allowed;
  logic              nest_full;
  logic              head_avail;
  prio_t             kick_level;
  logic              kick_hit;

  npd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q_cmd),
    .stat  (q_stat)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && (state_r == S_IDLE);

  assign depth_m1   = depth_r - 1'b1;
  assign allowed    = ($signed(prio_r) >= $signed(level_r)) && !postp_r;
  assign nest_full  = (depth_r == NC_W'(NEST_DEPTH));
  assign head_avail = (q_stat.count != '0);
  assign kick_level = (typ_r == REQ_RESTORE) ? prio_r : level_r;
  assign kick_hit   = head_avail && ($signed(q_stat.head.prio) > $signed(kick_level));
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt      = state_r;
    level_nxt      = level_r;
    postp_nxt      = postp_r;
    depth_nxt      = depth_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_sprio_nxt  = res_sprio_r;
    res_prev_nxt   = res_prev_r;
    stk_we         = 1'b0;
    q_cmd.ins      = 1'b0;
    q_cmd.take     = 1'b0;
    q_cmd.ent.prio = prio_r;
    q_cmd.ent.tag  = tag_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        res_status_nxt = ST_REFUSED;
        res_tag_nxt    = '0;
        res_sprio_nxt  = '0;
        res_prev_nxt   = '0;
        state_nxt      = S_OUT;
        case (typ_r)
          REQ_CALL: begin
            if (allowed) begin
              if (nest_full) begin
                res_status_nxt = ST_NESTERR;
              end else begin
                stk_we         = 1'b1;
                depth_nxt      = depth_r + 1'b1;
                level_nxt      = prio_r;
                res_tag_nxt    = tag_r;
                res_sprio_nxt  = prio_r;
                res_status_nxt = ST_STARTED;
              end
            end else if (q_stat.count == QC_W'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_DROPPED;
            end else begin
              q_cmd.ins      = 1'b1;
              res_status_nxt = ST_QUEUED;
              state_nxt      = S_WAITQ;
            end
          end
          REQ_DONE: begin
            if (depth_r == '0) begin
              res_status_nxt = ST_NESTERR;
            end else if (head_avail &&
                         $signed(q_stat.head.prio) > $signed(stk_rdata_r)) begin
              q_cmd.take     = 1'b1;
              level_nxt      = q_stat.head.prio;
              res_tag_nxt    = q_stat.head.tag;
              res_sprio_nxt  = q_stat.head.prio;
              res_status_nxt = ST_STARTED;
              state_nxt      = S_WAITQ;
            end else begin
              level_nxt      = stk_rdata_r;
              depth_nxt      = depth_m1;
              res_status_nxt = ST_BACK;
            end
          end
          REQ_POSTPONE: begin
            postp_nxt      = 1'b1;
            res_status_nxt = ST_OK;
          end
          REQ_RESUME, REQ_RESTORE: begin
            if (typ_r == REQ_RESUME) begin
              postp_nxt = 1'b0;
            end else begin
              level_nxt = prio_r;
            end
            if ((typ_r == REQ_RESTORE && postp_r) || !kick_hit) begin
              res_status_nxt = ST_OK;
            end else if (nest_full) begin
              res_status_nxt = ST_NESTERR;
            end else begin
              stk_we         = 1'b1;
              depth_nxt      = depth_r + 1'b1;
              q_cmd.take     = 1'b1;
              level_nxt      = q_stat.head.prio;
              res_tag_nxt    = q_stat.head.tag;
              res_sprio_nxt  = q_stat.head.prio;
              res_status_nxt = ST_STARTED;
              state_nxt      = S_WAITQ;
            end
          end
          REQ_RAISE: begin
            if (allowed) begin
              res_prev_nxt   = level_r;
              level_nxt      = prio_r;
              res_status_nxt = ST_OK;
            end
          end
          REQ_CHECK: begin
            res_status_nxt = allowed ? ST_OK : ST_REFUSED;
          end
          default: begin
            res_status_nxt = ST_REFUSED;
          end
        endcase
      end
      S_WAITQ: begin
        if (!q_stat.busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '1;
      postp_r     <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      postp_r     <= postp_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      typ_r  <= in_req.req_type;
      prio_r <= in_req.priority_req;
      tag_r  <= in_req.job_tag;
    end
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_sprio_r  <= res_sprio_nxt;
    res_prev_r   <= res_prev_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_tag_r    <= res_tag_r;
      out_sprio_r  <= res_sprio_r;
      out_prev_r   <= res_prev_r;
      out_level_r  <= level_r;
      out_count_r  <= q_stat.count;
      out_postp_r  <= postp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[depth_r[NA_W-1:0]] <= kick_level;
    end
    stk_rdata_r <= stack[depth_m1[NA_W-1:0]];
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.start_tag      = out_tag_r;
  assign out_rsp.start_priority = out_sprio_r;
  assign out_rsp.previous_level = out_prev_r;
  assign out_rsp.current_level  = out_level_r;
  assign out_rsp.pending_count  = out_count_r;
  assign out_rsp.postponed      = out_postp_r;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for nested_priority_dispatcher_unit: directed and random
// requests against an in-bench dispatcher predictor, with random stalls on both sides.
// Depends on npd_pkg, npd_if and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_top import npd_pkg::*; ();

  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 3'd7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    tag_t              start_tag;
    prio_t             start_priority;
    prio_t             previous_level;
    prio_t             current_level;
    logic [QC_W-1:0]   pending_count;
    logic              postponed;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  npd_in_if  req_if ();
  npd_out_if rsp_if ();

  nested_priority_dispatcher_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted dispatcher state.
  int    run_lvl;
  bit    postp;
  int    q_prio [QUEUE_DEPTH];
  tag_t  q_tag [QUEUE_DEPTH];
  int    q_cnt;
  int    nest_lvl [NEST_DEPTH];
  int    nest_cnt;
  int    last_prev;

  rsp_t  expected_rsp [$];
  int    errors;
  int    n_sent;
  int    n_checked;
  int    cycles;
  int    stall_left;
  bit    calm;
  int    status_seen [8];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic prio_t rand_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return prio_t'($urandom_range(0, 7));
    if (r < 60) return -1;
    if (r < 70) return 255;
    if (r < 92) return prio_t'($urandom_range(0, 255));
    return prio_t'($urandom);
  endfunction

  task automatic queue_take(output int pr, output tag_t tg);
    pr = q_prio[0];
    tg = q_tag[0];
    for (int i = 1; i < q_cnt; i++) begin
      q_prio[i-1] = q_prio[i];
      q_tag[i-1]  = q_tag[i];
    end
    q_cnt--;
  endtask

  task automatic kick_pending(inout rsp_t e);
    int   hp;
    tag_t ht;
    if (q_cnt == 0 || q_prio[0] <= run_lvl) begin
      e.status = ST_OK;
    end else if (nest_cnt >= NEST_DEPTH) begin
      e.status = ST_NESTERR;
    end else begin
      nest_lvl[nest_cnt] = run_lvl;
      nest_cnt++;
      queue_take(hp, ht);
      run_lvl = hp;
      e.start_tag      = ht;
      e.start_priority = hp[PRIO_W-1:0];
      e.status         = ST_STARTED;
    end
  endtask

  task automatic predict_rsp(input logic [TYPE_W-1:0] rt, input prio_t pr, input tag_t tg);
    rsp_t e;
    int   p;
    int   pos;
    bit   allowed;
    int   hp;
    tag_t ht;
    p = int'(pr);
    e = '0;
    e.status = ST_REFUSED;
    allowed = (p >= run_lvl) && !postp;
    case (rt)
      REQ_CALL: begin
        if (allowed) begin
          if (nest_cnt >= NEST_DEPTH) begin
            e.status = ST_NESTERR;
          end else begin
            nest_lvl[nest_cnt] = run_lvl;
            nest_cnt++;
            run_lvl = p;
            e.start_tag      = tg;
            e.start_priority = pr;
            e.status         = ST_STARTED;
          end
        end else if (q_cnt >= QUEUE_DEPTH) begin
          e.status = ST_DROPPED;
        end else begin
          // Equal priorities keep arrival order.
          pos = 0;
          while (pos < q_cnt && q_prio[pos] >= p) pos++;
          for (int i = q_cnt; i > pos; i--) begin
            q_prio[i] = q_prio[i-1];
            q_tag[i]  = q_tag[i-1];
          end
          q_prio[pos] = p;
          q_tag[pos]  = tg;
          q_cnt++;
          e.status = ST_QUEUED;
        end
      end
      REQ_DONE: begin
        if (nest_cnt == 0) begin
          e.status = ST_NESTERR;
        end else if (q_cnt > 0 && q_prio[0] > nest_lvl[nest_cnt-1]) begin
          queue_take(hp, ht);
          run_lvl = hp;
          e.start_tag      = ht;
          e.start_priority = hp[PRIO_W-1:0];
          e.status         = ST_STARTED;
        end else begin
          nest_cnt--;
          run_lvl  = nest_lvl[nest_cnt];
          e.status = ST_BACK;
        end
      end
      REQ_POSTPONE: begin
        postp    = 1'b1;
        e.status = ST_OK;
      end
      REQ_RESUME: begin
        postp = 1'b0;
        kick_pending(e);
      end
      REQ_RAISE: begin
        if (allowed) begin
          e.previous_level = run_lvl[PRIO_W-1:0];
          last_prev = run_lvl;
          run_lvl   = p;
          e.status  = ST_OK;
        end
      end
      REQ_RESTORE: begin
        run_lvl = p;
        if (postp) e.status = ST_OK;
        else kick_pending(e);
      end
      REQ_CHECK: begin
        e.status = allowed ? ST_OK : ST_REFUSED;
      end
      default: begin
      end
    endcase
    e.current_level = run_lvl[PRIO_W-1:0];
    e.pending_count = q_cnt[QC_W-1:0];
    e.postponed     = postp;
    status_seen[e.status]++;
    expected_rsp.push_back(e);
  endtask

  task automatic send_req(input logic [TYPE_W-1:0] rt, input prio_t pr, input tag_t tg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= rt;
    req_if.priority_req <= pr;
    req_if.job_tag      <= tg;
    do @(posedge clk); while (!req_if.ready);
    predict_rsp(rt, pr, tg);
    n_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_requests();
    send_req(REQ_CHECK, -1, 16'h0000);
    send_req(REQ_CALL, 5, 16'h0000);
    send_req(REQ_CALL, 3, 16'hFFFF);
    send_req(REQ_CHECK, 4, 16'h0001);
    send_req(REQ_RAISE, 10, 16'h0002);
    send_req(REQ_RAISE, 7, 16'h0003);
    send_req(REQ_POSTPONE, 0, 16'h0004);
    send_req(REQ_CALL, 200, 16'h1234);
    send_req(REQ_CHECK, 255, 16'h0005);
    send_req(REQ_RAISE, 255, 16'h0006);
    send_req(REQ_RESTORE, 2, 16'h0007);
    send_req(REQ_RESUME, 0, 16'h0008);
    send_req(REQ_DONE, 0, 16'h0009);
    send_req(REQ_DONE, 0, 16'h000A);
    send_req(REQ_UNKNOWN, 255, 16'hFFFF);
    send_req(REQ_CALL, 255, 16'hABCD);
    send_req(REQ_CALL, -1, 16'h5A5A);
    send_req(REQ_RESTORE, -1, 16'h000B);
    send_req(REQ_RAISE, 255, 16'h000C);
    send_req(REQ_DONE, 0, 16'h000D);
    send_req(REQ_DONE, 0, 16'h000E);
    send_req(REQ_DONE, 0, 16'h000F);
    send_req(REQ_RESUME, 0, 16'h0010);
    send_req(REQ_RESTORE, -2, 16'h0011);
    send_req(REQ_DONE, 0, 16'h0012);
    send_req(REQ_RESTORE, -1, 16'h0013);
    wait_drain();
  endtask

  task automatic test_nesting_limit();
    for (int i = 0; i < NEST_DEPTH; i++) begin
      send_req(REQ_CALL, prio_t'(i), tag_t'(16'h0100 + i));
    end
    send_req(REQ_CALL, 20, 16'h0200);
    send_req(REQ_POSTPONE, 0, 16'h0201);
    send_req(REQ_CALL, 100, 16'h0202);
    send_req(REQ_RESUME, 0, 16'h0203);
    send_req(REQ_RESTORE, 5, 16'h0204);
    send_req(REQ_DONE, 0, 16'h0205);
    for (int i = 0; i < NEST_DEPTH; i++) send_req(REQ_DONE, 0, tag_t'(16'h0300 + i));
    wait_drain();
  endtask

  task automatic test_queue_full();
    send_req(REQ_CALL, 255, 16'h0400);
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      send_req(REQ_CALL, prio_t'((i % 4) * 10), tag_t'(16'h0500 + i));
    end
    for (int i = 0; i <= QUEUE_DEPTH; i++) send_req(REQ_DONE, 0, tag_t'(16'h0600 + i));
    wait_drain();
  endtask

  // Mode 0 runs without gaps, mode 1 with gaps, mode 2 alternates and pauses halfway.
  task automatic test_random_traffic(input int n_items, input int mode);
    logic [TYPE_W-1:0] rt;
    prio_t             pr;
    int                r;
    for (int k = 0; k < n_items; k++) begin
      if (mode == 2) calm = ((k / 25) % 2) == 0;
      else calm = (mode == 0);
      if (mode == 2 && k == n_items / 2) wait_drain();
      r = $urandom_range(0, 99);
      if (r < 34) rt = REQ_CALL;
      else if (r < 64) rt = REQ_DONE;
      else if (r < 70) rt = REQ_POSTPONE;
      else if (r < 78) rt = REQ_RESUME;
      else if (r < 85) rt = REQ_RAISE;
      else if (r < 92) rt = REQ_RESTORE;
      else if (r < 98) rt = REQ_CHECK;
      else rt = REQ_UNKNOWN;
      pr = rand_prio();
      if (rt == REQ_RESTORE && $urandom_range(0, 1) == 1) pr = last_prev[PRIO_W-1:0];
      send_req(rt, pr, tag_t'($urandom_range(0, 65535)));
    end
    calm = 1'b0;
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : rsp_checker
    rsp_t got;
    rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.status         = rsp_if.status;
      got.start_tag      = rsp_if.start_tag;
      got.start_priority = rsp_if.start_priority;
      got.previous_level = rsp_if.previous_level;
      got.current_level  = rsp_if.current_level;
      got.pending_count  = rsp_if.pending_count;
      got.postponed      = rsp_if.postponed;
      n_checked++;
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: status %0d level %0d",
                                   got.status, got.current_level);
      end else begin
        want = expected_rsp.pop_front();
        if (got.status !== want.status || got.start_tag !== want.start_tag ||
            got.start_priority !== want.start_priority ||
            got.previous_level !== want.previous_level ||
            got.current_level !== want.current_level ||
            got.pending_count !== want.pending_count ||
            got.postponed !== want.postponed) begin
          errors++;
          if (errors <= 10) begin
            $display({"Mismatch on result %0d: expected st=%0d tag=%h sp=%0d",
                      " prev=%0d cur=%0d cnt=%0d pp=%0d"},
                     n_checked, want.status, want.start_tag, want.start_priority,
                     want.previous_level, want.current_level, want.pending_count,
                     want.postponed);
            $display("    actual st=%0d tag=%h sp=%0d prev=%0d cur=%0d cnt=%0d pp=%0d",
                     got.status, got.start_tag, got.start_priority, got.previous_level,
                     got.current_level, got.pending_count, got.postponed);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, expected_rsp.size());
      $display("[nested_priority_dispatcher_unit] ERROR");
      $finish;
    end
  end

  initial begin
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_CALL;
    req_if.priority_req = '0;
    req_if.job_tag      = '0;
    run_lvl   = -1;
    postp     = 1'b0;
    q_cnt     = 0;
    nest_cnt  = 0;
    last_prev = -1;
    calm      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_requests();
    test_nesting_limit();
    test_queue_full();
    test_random_traffic(75, 0);
    test_random_traffic(125, 1);
    test_random_traffic(150, 2);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests and checked %0d results; %0d mismatches.",
             n_sent, n_checked, errors);
    $display({"Started %0d, queued %0d, back %0d, ok %0d, dropped %0d,",
              " refused %0d, nest errors %0d."},
             status_seen[ST_STARTED], status_seen[ST_QUEUED], status_seen[ST_BACK],
             status_seen[ST_OK], status_seen[ST_DROPPED], status_seen[ST_REFUSED],
             status_seen[ST_NESTERR]);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("[nested_priority_dispatcher_unit] OK");
    end else begin
      $display("[nested_priority_dispatcher_unit] ERROR");
    end
    $finish;
  end

endmodule
